@@ rtl/core/fds_pkg.sv @@
// fds_pkg: shared types, constants and the tanh table series for the fuzz stage
// used by every file under rtl/core; depends on nothing
`default_nettype none

package fds_pkg;

  localparam int SampleBitsDef = 16;
  localparam int TanhAddrBitsDef = 10;
  localparam int FracBitsDef = 28;
  localparam int CfgDataBits = 17;
  localparam int CfgIdxBits = 3;

  typedef logic signed [65:0] acc_t;
  typedef logic signed [32:0] opnd_t;

  localparam opnd_t Q31_ATTACK = 33'sd21474836;
  localparam opnd_t Q31_RELEASE = 33'sd1073742;
  localparam opnd_t Q31_POLE = 33'sd2136746230;
  localparam opnd_t Q31_CUT_BASE = 33'sd42949673;
  localparam opnd_t Q31_CUT_SPAN = 33'sd966367642;
  localparam opnd_t Q31_GATE = 33'sd171798692;
  localparam opnd_t Q16_GAIN = 33'sd104858;

  typedef enum logic [2:0] {
    REG_DRIVE  = 3'd0,
    REG_BIAS   = 3'd1,
    REG_GATE   = 3'd2,
    REG_TONE   = 3'd3,
    REG_LEVEL  = 3'd4,
    REG_MIX    = 3'd5
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_POST,
    ST_RD0,
    ST_RD1,
    ST_DIV
  } ctrl_state_e;

  typedef enum logic [3:0] {
    OP_ENV,
    OP_DRV,
    OP_INT,
    OP_GAIN,
    OP_POLE,
    OP_CUT,
    OP_LP,
    OP_LVL,
    OP_THR,
    OP_WENV,
    OP_MIXD,
    OP_MIXW
  } op_e;

  typedef struct packed {
    ctrl_state_e state;
    op_e         op;
    logic        accept;
  } cmd_t;

  typedef struct packed {
    logic gate_on;
    logic div_done;
    logic out_free;
  } status_t;

  function automatic logic signed [31:0] sat32(acc_t v);
    if (v > acc_t'(32'sh7fffffff)) begin
      return 32'sh7fffffff;
    end else if (v < -acc_t'(33'sh080000000)) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // shift-subtract divide, only evaluated while the rom is elaborated
  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
    logic [63:0] q;
    logic [64:0] rem;
    q = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem = rem - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // tanh(4k/N) in Q1.15, e^(2x) from a Q.24 series raised to the 16th power
  function automatic logic signed [15:0] tanh_entry(int k, int abits);
    logic [63:0] mag;
    logic [63:0] z;
    logic [63:0] term;
    logic [63:0] e;
    logic [63:0] r;
    logic [63:0] one;
    one = 64'd1 << 24;
    mag = (k < 0) ? 64'(-k) : 64'(k);
    z = (mag << (27 - abits)) >> 4;
    term = one;
    e = one;
    for (int n = 1; n <= 12; n++) begin
      term = udiv64((term * z) >> 24, 64'(n));
      e = e + term;
    end
    for (int j = 0; j < 4; j++) begin
      e = (e * e) >> 24;
    end
    r = udiv64((e - one) * 64'd32768 + ((e + one) >> 1), e + one);
    return (k < 0) ? -$signed(r[15:0]) : $signed(r[15:0]);
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/fds_stream_if.sv @@
// fds_in_if and fds_out_if: valid/ready sample channels of the fuzz stage
// depends on fds_pkg for the default sample width
`default_nettype none

interface fds_in_if #(
  parameter int SAMPLE_BITS = fds_pkg::SampleBitsDef
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic                          block_end_in;

  modport source (output valid, output sample_in, output block_end_in, input ready);
  modport sink (input valid, input sample_in, input block_end_in, output ready);
endinterface

interface fds_out_if #(
  parameter int SAMPLE_BITS = fds_pkg::SampleBitsDef
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          block_end_out;

  modport source (output valid, output sample_out, output block_end_out, input ready);
  modport sink (input valid, input sample_out, input block_end_out, output ready);
endinterface

`default_nettype wire

@@ rtl/core/fds_ctrl.sv @@
// fds_ctrl: sequencer of the fuzz stage, steps the datapath through its operations
// depends on fds_pkg
`default_nettype none

module fds_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  fds_pkg::status_t status_i,
  output fds_pkg::cmd_t    cmd_o
);
  import fds_pkg::*;

  ctrl_state_e state_q, state_d;
  op_e         op_q, op_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_ENV;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    in_ready_o = (state_q == ST_IDLE);
    cmd_o.state  = state_q;
    cmd_o.op     = op_q;
    cmd_o.accept = (state_q == ST_IDLE) && in_valid_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_MUL;
          op_d    = OP_ENV;
        end
      end
      ST_MUL: state_d = ST_POST;
      ST_RD0: state_d = ST_RD1;
      ST_RD1: begin
        state_d = ST_MUL;
        op_d    = OP_INT;
      end
      ST_DIV: begin
        if (status_i.div_done) begin
          state_d = ST_MUL;
          op_d    = OP_MIXD;
        end
      end
      ST_POST: begin
        state_d = ST_MUL;
        unique case (op_q)
          OP_ENV:  op_d = OP_DRV;
          OP_DRV:  state_d = ST_RD0;
          OP_INT:  op_d = OP_GAIN;
          OP_GAIN: op_d = OP_POLE;
          OP_POLE: op_d = OP_CUT;
          OP_CUT:  op_d = OP_LP;
          OP_LP:   op_d = OP_LVL;
          OP_LVL:  op_d = OP_THR;
          OP_THR:  op_d = status_i.gate_on ? OP_WENV : OP_MIXD;
          OP_WENV: state_d = ST_DIV;
          OP_MIXD: op_d = OP_MIXW;
          OP_MIXW: state_d = status_i.out_free ? ST_IDLE : ST_POST;
          default: state_d = ST_IDLE;
        endcase
      end
      default: state_d = ST_IDLE;
    endcase
  end

  a_mul_post: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MUL |=> state_q == ST_POST) else $error("multiply not followed by post");
  a_rd_int: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RD1 |=> state_q == ST_MUL && op_q == OP_INT)
    else $error("table read not followed by interpolation");
  a_div_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV && !status_i.div_done |=> state_q == ST_DIV)
    else $error("divider left early");

endmodule

`default_nettype wire

@@ rtl/core/fds_datapath.sv @@
// fds_datapath: config registers, filter state, shared multiplier, tanh rom,
// gate divider and output register; driven by fds_ctrl, depends on fds_pkg
`default_nettype none

module fds_datapath #(
  parameter int SAMPLE_BITS = fds_pkg::SampleBitsDef,
  parameter int TANH_TABLE_ADDR_BITS = fds_pkg::TanhAddrBitsDef,
  parameter int INTERNAL_FRAC_BITS = fds_pkg::FracBitsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  fds_pkg::cmd_t                       cmd_i,
  output fds_pkg::status_t                    status_o,
  input  logic signed [SAMPLE_BITS-1:0]       sample_in_i,
  input  logic                                block_end_in_i,
  input  logic                                cfg_we_i,
  input  logic [fds_pkg::CfgIdxBits-1:0]      cfg_idx_i,
  input  logic [fds_pkg::CfgDataBits-1:0]     cfg_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]       sample_out_o,
  output logic                                block_end_out_o
);
  import fds_pkg::*;

  localparam int S = SAMPLE_BITS;
  localparam int F = INTERNAL_FRAC_BITS;
  localparam int A = TANH_TABLE_ADDR_BITS;
  localparam int Tab = 1 << A;
  localparam int HalfTab = Tab / 2;
  localparam int SH = F + 2 - A;
  localparam int DryL = (F >= S - 1) ? F - S + 1 : 0;
  localparam int DryR = (F >= S - 1) ? 0 : S - 1 - F;
  localparam int DrvL = (F >= S + 7) ? F - S - 7 : 0;
  localparam int DrvR = (F >= S + 7) ? 0 : S + 7 - F;
  localparam int OutL = (S - 1 >= F) ? S - 1 - F : 0;
  localparam int OutR = (S - 1 >= F) ? 0 : F - S + 1;
  localparam acc_t OneQ = acc_t'(1) <<< F;
  localparam acc_t TwoQ = acc_t'(1) <<< (F + 1);
  localparam acc_t SMax = (acc_t'(1) <<< (S - 1)) - acc_t'(1);
  localparam acc_t SMin = -(acc_t'(1) <<< (S - 1));

  typedef logic signed [15:0] rom_t [Tab];

  function automatic rom_t build_rom();
    rom_t r;
    for (int i = 0; i < Tab; i++) begin
      r[i] = tanh_entry(i - HalfTab, A);
    end
    return r;
  endfunction

  localparam rom_t TanhRom = build_rom();

  // configuration
  logic [14:0]        drive_q;
  logic signed [15:0] bias_q;
  logic [16:0]        gate_q, tone_q, mix_q;
  logic [15:0]        level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drive_q <= 15'd2560;
      bias_q  <= 16'sd0;
      gate_q  <= 17'd0;
      tone_q  <= 17'd32768;
      level_q <= 16'd16384;
      mix_q   <= 17'd65536;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_DRIVE: drive_q <= cfg_data_i[14:0];
        REG_BIAS:  bias_q  <= $signed(cfg_data_i[15:0]);
        REG_GATE:  gate_q  <= cfg_data_i;
        REG_TONE:  tone_q  <= cfg_data_i;
        REG_LEVEL: level_q <= cfg_data_i[15:0];
        REG_MIX:   mix_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [14:0]        drive_c;
  logic signed [15:0] bias_c;
  logic [16:0]        gate_c, tone_c, mix_c;
  logic [15:0]        level_c;

  always_comb begin
    drive_c = (drive_q < 15'd256) ? 15'd256 : ((drive_q > 15'd25600) ? 15'd25600 : drive_q);
    bias_c  = (bias_q < -16'sd16384) ? -16'sd16384 :
              ((bias_q > 16'sd16384) ? 16'sd16384 : bias_q);
    gate_c  = (gate_q > 17'd65536) ? 17'd65536 : gate_q;
    tone_c  = (tone_q > 17'd65536) ? 17'd65536 : tone_q;
    mix_c   = (mix_q > 17'd65536) ? 17'd65536 : mix_q;
    level_c = (level_q > 16'd32768) ? 16'd32768 : level_q;
  end

  // per-item and filter state
  logic signed [S-1:0] s_q;
  logic                blk_q;
  logic signed [31:0]  dry_q, env_q, dcin_q, dcout_q, lp_q, x_q, cut_q, wet_q, thr_q;
  logic signed [15:0]  t_q, rom_q, t2_q;
  logic [A-1:0]        idx_q;
  logic [SH-1:0]       frac_q;
  acc_t                prod_q, acc_q;
  logic [30:0]         rem_q;
  logic [31:0]         dq_q;
  logic                neg_q;
  logic [4:0]          div_cnt_q;
  logic                out_vld_q;

  // operand select for the shared multiplier
  logic signed [32:0] rect, d_env;
  logic signed [31:0] lp_diff;
  opnd_t              op_a, op_b;

  always_comb begin
    rect    = dry_q[31] ? -(33'(dry_q)) : 33'(dry_q);
    d_env   = rect - 33'(env_q);
    lp_diff = sat32(acc_t'(dcout_q) - acc_t'(lp_q));
    op_a = '0;
    op_b = '0;
    case (cmd_i.op)
      OP_ENV: begin
        op_a = (rect > 33'(env_q)) ? Q31_ATTACK : Q31_RELEASE;
        op_b = d_env;
      end
      OP_DRV: begin
        op_a = 33'(s_q);
        op_b = $signed({18'b0, drive_c});
      end
      OP_INT: begin
        op_a = 33'(rom_q) - 33'(t_q);
        op_b = $signed({{(33 - SH){1'b0}}, frac_q});
      end
      OP_GAIN: begin
        op_a = 33'(t2_q);
        op_b = Q16_GAIN;
      end
      OP_POLE: begin
        op_a = Q31_POLE;
        op_b = 33'(dcout_q);
      end
      OP_CUT: begin
        op_a = $signed({16'b0, tone_c});
        op_b = Q31_CUT_SPAN;
      end
      OP_LP: begin
        op_a = 33'(cut_q);
        op_b = 33'(lp_diff);
      end
      OP_LVL: begin
        op_a = 33'(lp_q);
        op_b = $signed({17'b0, level_c});
      end
      OP_THR: begin
        op_a = $signed({16'b0, gate_c});
        op_b = Q31_GATE;
      end
      OP_WENV: begin
        op_a = 33'(wet_q);
        op_b = 33'(env_q);
      end
      OP_MIXD: begin
        op_a = 33'(dry_q);
        op_b = $signed({15'b0, 18'd65536 - {1'b0, mix_c}});
      end
      OP_MIXW: begin
        op_a = 33'(wet_q);
        op_b = $signed({16'b0, mix_c});
      end
      default: ;
    endcase
  end

  // post-processing of the product
  acc_t               arg, arg_c, u_val, gain_s, mix_sum, o_val;
  logic signed [31:0] env_post, dc_post, lp_post, wet_post, thr_next, x_next, cut_next;
  logic signed [15:0] int_post;
  logic signed [31:0] dry_next;
  logic [63:0]        mag;
  logic [31:0]        trial;
  logic               ge;
  logic [31:0]        q_fin;
  logic signed [S-1:0] o_sat;

  always_comb begin
    dry_next = 32'((acc_t'(sample_in_i) <<< DryL) >>> DryR);
    env_post = sat32(acc_t'(env_q) + (prod_q >>> 31));
    arg   = ((prod_q <<< DrvL) >>> DrvR) + (acc_t'(bias_c) <<< (F - 15));
    arg_c = (arg < -TwoQ) ? -TwoQ : ((arg > TwoQ - acc_t'(1)) ? TwoQ - acc_t'(1) : arg);
    u_val = arg_c + TwoQ;
    int_post = 16'(acc_t'(t_q) + (prod_q >>> SH));
    gain_s = prod_q >>> (31 - F);
    x_next = 32'((gain_s < -OneQ) ? -OneQ : ((gain_s > OneQ) ? OneQ : gain_s));
    dc_post = sat32(acc_t'(x_q) - acc_t'(dcin_q) + (prod_q >>> 31));
    cut_next = 32'(acc_t'(Q31_CUT_BASE) + (prod_q >>> 16));
    lp_post = sat32(acc_t'(lp_q) + (prod_q >>> 31));
    wet_post = sat32(prod_q >>> 14);
    thr_next = 32'(prod_q >>> (47 - F));
    mag = 64'(prod_q[65] ? -prod_q : prod_q);
    trial = {rem_q, dq_q[31]};
    ge = trial >= {1'b0, thr_q[30:0]};
    q_fin = {dq_q[30:0], ge};
    mix_sum = acc_q + prod_q;
    o_val = ((mix_sum >>> 16) <<< OutL) >>> OutR;
    o_sat = S'((o_val < SMin) ? SMin : ((o_val > SMax) ? SMax : o_val));
  end

  assign status_o.gate_on  = (thr_next > 32'sd0) && (env_q < thr_next);
  assign status_o.div_done = (cmd_i.state == ST_DIV) && (div_cnt_q == 5'd31);
  assign status_o.out_free = !out_vld_q || out_ready_i;

  logic out_load;
  assign out_load = (cmd_i.state == ST_POST) && (cmd_i.op == OP_MIXW) && status_o.out_free;

  // filter state, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      env_q     <= '0;
      dcin_q    <= '0;
      dcout_q   <= '0;
      lp_q      <= '0;
      div_cnt_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (cmd_i.state == ST_POST) begin
        case (cmd_i.op)
          OP_ENV:  env_q <= env_post;
          OP_POLE: begin
            dcin_q  <= x_q;
            dcout_q <= dc_post;
          end
          OP_LP:   lp_q <= lp_post;
          OP_WENV: div_cnt_q <= '0;
          default: ;
        endcase
      end
      if (cmd_i.state == ST_DIV) begin
        div_cnt_q <= div_cnt_q + 5'd1;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      s_q   <= sample_in_i;
      blk_q <= block_end_in_i;
      dry_q <= dry_next;
    end
    if (cmd_i.state == ST_MUL) begin
      prod_q <= op_a * op_b;
    end
    if (cmd_i.state == ST_RD0) begin
      rom_q <= TanhRom[idx_q];
    end
    if (cmd_i.state == ST_RD1) begin
      t_q   <= rom_q;
      rom_q <= TanhRom[(idx_q == A'(Tab - 1)) ? idx_q : idx_q + A'(1)];
    end
    if (cmd_i.state == ST_POST) begin
      case (cmd_i.op)
        OP_DRV: begin
          idx_q  <= u_val[F+1:SH];
          frac_q <= u_val[SH-1:0];
        end
        OP_INT:  t2_q  <= int_post;
        OP_GAIN: x_q   <= x_next;
        OP_CUT:  cut_q <= cut_next;
        OP_LVL:  wet_q <= wet_post;
        OP_THR:  thr_q <= thr_next;
        OP_WENV: begin
          neg_q <= prod_q[65];
          rem_q <= mag[62:32];
          dq_q  <= mag[31:0];
        end
        OP_MIXD: acc_q <= prod_q;
        default: ;
      endcase
    end
    if (cmd_i.state == ST_DIV) begin
      // one quotient bit per cycle, remainder stays below the threshold
      rem_q <= ge ? 31'(trial - {1'b0, thr_q[30:0]}) : trial[30:0];
      dq_q  <= q_fin;
      if (status_o.div_done) begin
        wet_q <= neg_q ? -$signed(q_fin) : $signed(q_fin);
      end
    end
    if (out_load) begin
      sample_out_o    <= o_sat;
      block_end_out_o <= blk_q;
    end
  end

  assign out_valid_o = out_vld_q;

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.state == ST_DIV |-> rem_q < thr_q[30:0]) else $error("divider remainder too large");
  a_env_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !env_q[31]) else $error("envelope went negative");
  a_out_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_vld_q) else $error("result not presented");

endmodule

`default_nettype wire

@@ rtl/core/fuzz_distortion_stage_core.sv @@
// fuzz_distortion_stage_core: top level of the fuzz stage with noise gate
// depends on fds_pkg, fds_stream_if, fds_ctrl and fds_datapath
//
//   channel  dir  handshake     payload
//   in_ch    in   valid/ready   sample_in, block_end_in
//   out_ch   out  valid/ready   sample_out, block_end_out
//   cfg      in   cfg_we_i      cfg_idx_i, cfg_data_i
//
// items go one at a time through the single shared multiplier (MUL, then POST
// per product) and, when the gate is closing, the one-bit-per-cycle divider
// reset clears config to defaults and filter state to zero; no clearing pass
// a result waits in the output register while the next item is processed;
// the final transfer of that item stalls until the register is free
`default_nettype none

module fuzz_distortion_stage_core #(
  parameter int SAMPLE_BITS = fds_pkg::SampleBitsDef,
  parameter int TANH_TABLE_ADDR_BITS = fds_pkg::TanhAddrBitsDef,
  parameter int INTERNAL_FRAC_BITS = fds_pkg::FracBitsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  fds_in_if.sink                          in_ch,
  fds_out_if.source                       out_ch,
  input  logic                            cfg_we_i,
  input  logic [fds_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [fds_pkg::CfgDataBits-1:0] cfg_data_i
);
  import fds_pkg::*;

  cmd_t    cmd;
  status_t status;

  fds_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ch.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  fds_datapath #(
    .SAMPLE_BITS          (SAMPLE_BITS),
    .TANH_TABLE_ADDR_BITS (TANH_TABLE_ADDR_BITS),
    .INTERNAL_FRAC_BITS   (INTERNAL_FRAC_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .sample_in_i     (in_ch.sample_in),
    .block_end_in_i  (in_ch.block_end_in),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .out_valid_o     (out_ch.valid),
    .out_ready_i     (out_ch.ready),
    .sample_out_o    (out_ch.sample_out),
    .block_end_out_o (out_ch.block_end_out)
  );

endmodule

`default_nettype wire

@@ tb/fuzz_distortion_stage_core_tb.sv @@
// fuzz_distortion_stage_core_tb: self-checking bench for the fuzz stage with noise gate
// depends on fds_pkg, fds_stream_if and the fuzz_distortion_stage_core rtl
`default_nettype none

module fuzz_distortion_stage_core_tb;
  import fds_pkg::*;

  localparam int WatchdogLimit = 5000;
  localparam int DrainCycles = 120;

  typedef struct {
    logic signed [15:0] smp;
    logic               blk_end;
  } frame_t;

  class fuzz_scoreboard;
    localparam longint Attack = 21474836;
    localparam longint Release = 1073742;
    localparam longint Pole = 2136746230;
    localparam longint CutBase = 42949673;
    localparam longint CutSpan = 966367642;
    localparam longint GateK = 171798692;
    localparam longint Gain16 = 104858;
    localparam longint One = longint'(1) << 28;

    logic [16:0] regs [6];
    longint      env, dc_in, dc_out, lp_val;
    longint      tanh_lut [1024];
    frame_t      expected_q [$];
    int          errors;

    function new();
      for (int i = 0; i < 1024; i++) begin
        tanh_lut[i] = tanh_q15(i - 512);
      end
      regs[REG_DRIVE] = 17'd2560;
      regs[REG_BIAS] = 17'd0;
      regs[REG_GATE] = 17'd0;
      regs[REG_TONE] = 17'd32768;
      regs[REG_LEVEL] = 17'd16384;
      regs[REG_MIX] = 17'd65536;
      env = 0;
      dc_in = 0;
      dc_out = 0;
      lp_val = 0;
      errors = 0;
    endfunction

    // e^(2x) via a q.24 taylor series on 2x/16, squared four times
    function longint tanh_q15(int k);
      longint unsigned mag, z, term, e, r, eone;
      eone = 64'd1 << 24;
      mag = (k < 0) ? longint'(-k) : longint'(k);
      z = (mag << 17) >> 4;
      term = eone;
      e = eone;
      for (int n = 1; n <= 12; n++) begin
        term = ((term * z) >> 24) / n;
        e = e + term;
      end
      for (int j = 0; j < 4; j++) begin
        e = (e * e) >> 24;
      end
      r = ((e - eone) * 32768 + (e + eone) / 2) / (e + eone);
      return (k < 0) ? -longint'(r) : longint'(r);
    endfunction

    function longint clamp(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function longint sat(longint v);
      return clamp(v, -(longint'(1) << 31), (longint'(1) << 31) - 1);
    endfunction

    function void write_reg(reg_idx_e idx, logic [16:0] val);
      case (idx)
        REG_DRIVE: regs[idx] = {2'b0, val[14:0]};
        REG_BIAS, REG_LEVEL: regs[idx] = {1'b0, val[15:0]};
        default: regs[idx] = val;
      endcase
    endfunction

    function void note(frame_t f);
      longint s, dry, rect, arg, u, t, nx, x, dc, lp, wet, o;
      longint drv, bia, gt, tn, lv, mx, cut, thr;
      int idx;
      frame_t res;
      s = longint'(f.smp);
      drv = clamp(longint'(regs[REG_DRIVE]), 256, 25600);
      bia = clamp(longint'($signed(regs[REG_BIAS][15:0])), -16384, 16384);
      gt = clamp(longint'(regs[REG_GATE]), 0, 65536);
      tn = clamp(longint'(regs[REG_TONE]), 0, 65536);
      lv = clamp(longint'(regs[REG_LEVEL]), 0, 32768);
      mx = clamp(longint'(regs[REG_MIX]), 0, 65536);

      // envelope: fast attack, slow release
      dry = s * 8192;
      rect = (dry < 0) ? -dry : dry;
      env = sat(env + ((((rect > env) ? Attack : Release) * (rect - env)) >>> 31));

      arg = clamp(s * drv * 32 + bia * 8192, -2 * One, 2 * One - 1);
      u = arg + 2 * One;
      idx = int'(u >> 20);
      t = tanh_lut[idx];
      nx = (idx < 1023) ? tanh_lut[idx + 1] : t;
      t = t + (((nx - t) * (u & ((longint'(1) << 20) - 1))) >>> 20);
      x = clamp((t * Gain16) >>> 3, -One, One);

      dc = sat(x - dc_in + ((Pole * dc_out) >>> 31));
      dc_in = x;
      dc_out = dc;

      cut = CutBase + ((tn * CutSpan) >> 16);
      lp = sat(lp_val + ((cut * sat(dc - lp_val)) >>> 31));
      lp_val = lp;

      wet = sat((lp * lv) >>> 14);
      thr = (gt * GateK) >> 19;
      if (thr > 0 && env < thr) begin
        wet = wet * env / thr;
      end

      o = (dry * (65536 - mx) + wet * mx) >>> 16;
      o = clamp(o >>> 13, -32768, 32767);
      res.smp = o[15:0];
      res.blk_end = f.blk_end;
      expected_q.push_back(res);
    endfunction

    function void check(frame_t got);
      frame_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result sample %0d block_end %0b",
                 $time, got.smp, got.blk_end);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.smp !== want.smp) begin
        $display("%0t: sample_out expected %0d actual %0d", $time, want.smp, got.smp);
        errors++;
      end
      if (got.blk_end !== want.blk_end) begin
        $display("%0t: block_end_out expected %0b actual %0b",
                 $time, want.blk_end, got.blk_end);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_idx = '0;
  logic [16:0] cfg_data = '0;
  logic        no_idle = 1'b0;
  int          quiet_cycles = 0;

  fds_in_if  in_ch ();
  fds_out_if out_ch ();

  fuzz_scoreboard sb = new();

  fuzz_distortion_stage_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.sample_in = '0;
    in_ch.block_end_in = 1'b0;
    out_ch.ready = 1'b0;
  end

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int r;
    if (no_idle) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  // transfers seen at the rising edge
  always @(posedge clk_i) begin
    frame_t f;
    logic   seen;
    seen = 1'b0;
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        f.smp = in_ch.sample_in;
        f.blk_end = in_ch.block_end_in;
        sb.note(f);
        seen = 1'b1;
      end
      if (out_ch.valid && out_ch.ready) begin
        f.smp = out_ch.sample_out;
        f.blk_end = out_ch.block_end_out;
        sb.check(f);
        seen = 1'b1;
      end
      quiet_cycles <= seen ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // random backpressure on the result side
  initial begin
    int g;
    @(posedge rst_ni);
    forever begin
      g = gap_len();
      if (g > 0) begin
        out_ch.ready = 1'b0;
        repeat (g) @(negedge clk_i);
      end
      out_ch.ready = 1'b1;
      @(negedge clk_i);
    end
  end

  task automatic send(logic signed [15:0] smp, logic blk_end);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_ch.valid = 1'b0;
      repeat (g) @(negedge clk_i);
    end
    in_ch.valid = 1'b1;
    in_ch.sample_in = smp;
    in_ch.block_end_in = blk_end;
    do @(posedge clk_i); while (!(in_ch.valid && in_ch.ready));
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_ch.valid = 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [16:0] val);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_data = val;
    sb.write_reg(idx, val);
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  function automatic logic signed [15:0] rand_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      return 16'($urandom());
    end else if (r < 85) begin
      return 16'($urandom_range(0, 512) - 256);
    end else if (r < 95) begin
      return 16'sd0;
    end
    return ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
  endfunction

  task automatic set_phase(int ph);
    logic [16:0] v [6];
    case (ph)
      0: v = '{17'd256, 17'h1c000, 17'd0, 17'd0, 17'd0, 17'd0};
      1: v = '{17'd25600, 17'd16384, 17'd65536, 17'd65536, 17'd32768, 17'd65536};
      // raw values beyond the clamp ranges
      2: v = '{17'd0, 17'h08000, 17'h1ffff, 17'h1ffff, 17'h0ffff, 17'h1ffff};
      3: v = '{17'h07fff, 17'h07fff, 17'd65536, 17'd0, 17'd16384, 17'd65536};
      default: begin
        v[REG_DRIVE] = 17'($urandom_range(256, 25600));
        v[REG_BIAS] = 17'($urandom_range(0, 32768) - 16384);
        v[REG_GATE] = ($urandom_range(0, 2) == 0) ? 17'd0 : 17'($urandom_range(0, 65536));
        v[REG_TONE] = 17'($urandom_range(0, 65536));
        v[REG_LEVEL] = 17'($urandom_range(0, 32768));
        v[REG_MIX] = ($urandom_range(0, 3) == 0) ? 17'd65536 : 17'($urandom_range(0, 65536));
      end
    endcase
    for (int i = 0; i < 6; i++) begin
      write_reg(reg_idx_e'(i), v[i]);
    end
  endtask

  initial begin
    logic signed [15:0] edge_vals [8];
    int n;
    edge_vals = '{16'sh8000, 16'sh7fff, 16'sd0, -16'sd1, 16'sd1, 16'sh4000, -16'sh4000, 16'sd0};
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // full-scale swings, then silence so the envelope releases
    for (int i = 0; i < 16; i++) begin
      send(edge_vals[i % 8], i[0]);
    end
    for (int i = 0; i < 6; i++) begin
      send(16'sd0, 1'b0);
    end

    for (int ph = 0; ph < 9; ph++) begin
      wait_idle();
      set_phase(ph);
      no_idle = (ph % 3 == 1);
      n = 115;
      for (int i = 0; i < n; i++) begin
        send(rand_sample(), ($urandom_range(0, 7) == 0));
      end
      no_idle = 1'b0;
    end

    in_ch.valid = 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
